// File: rtl/core/tfr_pkg.sv
// Shared types and constants for the time-of-flight frame receiver.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package tfr_pkg;

    localparam int unsigned FRAME_LEN = 16;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);

    localparam logic [7:0] HDR0 = 8'h57;
    localparam logic [7:0] HDR1 = 8'h00;
    localparam logic [7:0] HDR2 = 8'hFF;

    localparam logic [23:0] DIST_OUT_OF_RANGE = 24'hFFFFFF;

    localparam logic [POS_W-1:0] POS_HDR0   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HDR2   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ID     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_DIST0  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_DIST1  = POS_W'(9);
    localparam logic [POS_W-1:0] POS_DIST2  = POS_W'(10);
    localparam logic [POS_W-1:0] POS_STR0   = POS_W'(12);
    localparam logic [POS_W-1:0] POS_STR1   = POS_W'(13);
    localparam logic [POS_W-1:0] POS_CSUM   = POS_W'(FRAME_LEN - 1);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd1;
    localparam logic [1:0] STATUS_WEAK  = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  sensor_id;
        logic [23:0] distance_mm;
        logic [15:0] signal_strength;
    } tfr_result_t;

endpackage

`default_nettype wire

// File: rtl/core/tfr_frame_track.sv
// Per-byte frame tracking: position counter, checksum, header check, field capture.
// Depends on tfr_pkg; builds the result on the checksum byte.
`default_nettype none

module tfr_frame_track
    import tfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_en,
    input  wire logic [7:0]  rx_byte,
    output logic             at_last,
    output tfr_result_t      result
);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       sum_reg,      sum_next;
    logic             hdr_ok_reg,   hdr_ok_next;
    logic [7:0]       id_reg,       id_next;
    logic [23:0]      dist_reg,     dist_next;
    logic [15:0]      str_reg,      str_next;

    assign at_last = (pos_reg == POS_CSUM);

    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        hdr_ok_next = hdr_ok_reg;
        id_next     = id_reg;
        dist_next   = dist_reg;
        str_next    = str_reg;
        if (byte_en) begin
            unique case (pos_reg)
                POS_HDR0:  if (rx_byte != HDR0) hdr_ok_next = 1'b0;
                POS_HDR1:  if (rx_byte != HDR1) hdr_ok_next = 1'b0;
                POS_HDR2:  if (rx_byte != HDR2) hdr_ok_next = 1'b0;
                POS_ID:    id_next = rx_byte;
                POS_DIST0: dist_next[7:0]   = rx_byte;
                POS_DIST1: dist_next[15:8]  = rx_byte;
                POS_DIST2: dist_next[23:16] = rx_byte;
                POS_STR0:  str_next[7:0]    = rx_byte;
                POS_STR1:  str_next[15:8]   = rx_byte;
                default: ;
            endcase
            if (at_last) begin
                pos_next    = '0;
                sum_next    = '0;
                hdr_ok_next = 1'b1;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                sum_next = sum_reg + rx_byte;
            end
        end
    end

    always_comb begin
        result.sensor_id       = id_reg;
        result.distance_mm     = dist_reg;
        result.signal_strength = str_reg;
        priority if (!hdr_ok_reg || (sum_reg != rx_byte)) begin
            result.status = STATUS_ERROR;
        end else if ((str_reg == '0) || (dist_reg == DIST_OUT_OF_RANGE)) begin
            result.status = STATUS_WEAK;
        end else begin
            result.status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            id_reg     <= '0;
            dist_reg   <= '0;
            str_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            hdr_ok_reg <= hdr_ok_next;
            id_reg     <= id_next;
            dist_reg   <= dist_next;
            str_reg    <= str_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tfr_out_reg.sv
// Result register for the frame receiver output channel.
// Depends on tfr_pkg for the result record type.
`default_nettype none

module tfr_out_reg
    import tfr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  tfr_result_t       load_data,
    output logic              can_load,
    output logic              m_valid,
    input  wire logic         m_ready,
    output tfr_result_t       m_data
);

    logic        valid_reg, valid_next;
    tfr_result_t data_reg,  data_next;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/tof_frame_receiver.sv
// Time-of-flight frame receiver top level.
// Depends on tfr_pkg, tfr_frame_track and tfr_out_reg.
//
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte carries one link byte per request.
//   Bytes are grouped into 16-byte frames by position alone; there is no
//   resync on the header. Each 16th byte (checksum) produces one result on
//   m_valid/m_ready with m_status, m_sensor_id, m_distance_mm and
//   m_signal_strength.
//   Throughput: one byte per cycle while s_ready is high. The result appears in
//   the cycle after the checksum byte is accepted, from a single output register.
//   Stall: while a result waits in the output register, bytes 0 to 14 of the
//   next frame are still taken; s_ready drops only for a checksum byte that
//   would need the occupied register, and returns when m_ready takes it.
//   Reset (aresetn low, synchronous): position and checksum clear, header
//   flag sets, captured fields clear, output register is emptied.
`default_nettype none

module tof_frame_receiver
    import tfr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_rx_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_status,
    output logic [7:0]        m_sensor_id,
    output logic [23:0]       m_distance_mm,
    output logic [15:0]       m_signal_strength
);

    logic        at_last;
    logic        can_load;
    logic        byte_en;
    tfr_result_t frame_res;
    tfr_result_t out_res;

    assign s_ready = !at_last || can_load;
    assign byte_en = s_valid && s_ready;

    tfr_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (s_rx_byte),
        .at_last (at_last),
        .result  (frame_res)
    );

    tfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (byte_en && at_last),
        .load_data (frame_res),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_res)
    );

    assign m_status          = out_res.status;
    assign m_sensor_id       = out_res.sensor_id;
    assign m_distance_mm     = out_res.distance_mm;
    assign m_signal_strength = out_res.signal_strength;

endmodule

`default_nettype wire

// File: rtl/core/tfr_checker.sv
// Port-level checks for tof_frame_receiver, attached by bind.
// Depends on tfr_pkg for frame length and status codes.
`default_nettype none

module tfr_checker
    import tfr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [7:0]  m_sensor_id,
    input wire logic [23:0] m_distance_mm,
    input wire logic [15:0] m_signal_strength
);

    logic [POS_W-1:0] cnt_reg;
    logic             last_fire;

    assign last_fire = s_valid && s_ready && (cnt_reg == POS_CSUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_valid && s_ready) begin
            cnt_reg <= cnt_reg + POS_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_sensor_id)
            && $stable(m_distance_mm) && $stable(m_signal_strength))
        else $error("result changed while stalled");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        last_fire |=> m_valid)
        else $error("checksum byte produced no result");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid && !m_ready) |-> $past(last_fire))
        else $error("result without a completed frame");

    a_ok_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_OK) |->
            (m_signal_strength != '0) && (m_distance_mm != DIST_OUT_OF_RANGE))
        else $error("valid status with weak or out-of-range reading");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK) || (m_status == STATUS_ERROR)
            || (m_status == STATUS_WEAK))
        else $error("undefined status code");

endmodule

bind tof_frame_receiver tfr_checker u_tfr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_sensor_id       (m_sensor_id),
    .m_distance_mm     (m_distance_mm),
    .m_signal_strength (m_signal_strength)
);

`default_nettype wire
